FILE: hw/rtl/joystick_servo_conditioner_unit_assert.svh
// ----------------------------------------------------------------------------
// joystick servo conditioner assertion macros
// Concurrent assertion wrappers; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_SERVO_CONDITIONER_UNIT_ASSERT_SVH
`define JOYSTICK_SERVO_CONDITIONER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// assertion on an explicit clock and active-low reset
`define JSC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion on the block clock and reset
`define JSC_ASSERT(lbl, prop, msg) `JSC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define JSC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define JSC_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/jsc_pkg.sv
// ----------------------------------------------------------------------------
// jsc_pkg
// Types and constants of the joystick servo conditioner.
// ----------------------------------------------------------------------------
package jsc_pkg;

  // channel and sample geometry
  localparam int CHANNELS    = 3;
  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 8;
  localparam int WEIGHT_BITS = 8;
  localparam int POS_BITS    = SAMPLE_BITS + FRAC_BITS;
  localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
  localparam int CENTRE      = 1 << (SAMPLE_BITS - 1);

  // frame layout
  localparam logic [7:0] FRAME_START = 8'hAA;
  localparam int FRAME_LEN = 2 * CHANNELS + 2;

  // register map
  localparam int NUM_REGS      = 2 * CHANNELS + 2;
  localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
  localparam int REG_DEADZONE  = 2 * CHANNELS;
  localparam int REG_WEIGHT    = 2 * CHANNELS + 1;
  localparam int CFG_DATA_BITS = SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // calibration reset values, by channel
  localparam sample_t LOW_RESET_TBL [8] = '{
    12'd100, 12'd100, 12'd200, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0
  };
  localparam sample_t HIGH_RESET_TBL [8] = '{
    12'd4000, 12'd4000, 12'd3800, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095
  };
  localparam sample_t DEADZONE_RESET = 12'd30;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 8'd100;

  // input transaction
  typedef struct packed {
    sample_t sample_base;
    sample_t sample_shoulder;
    sample_t sample_elbow;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_t;

endpackage

FILE: hw/rtl/joystick_servo_conditioner_unit.sv
// ----------------------------------------------------------------------------
// joystick_servo_conditioner_unit
// Remaps, deadzones and low-pass filters three joystick samples and sends the
// positions as an eight-byte servo frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | three raw samples (in_t)
//  out     | output    | out_valid / out_ready| one frame byte and end flag (out_t)
//  cfg     | input     | cfg_we               | register index and write data
//
// Each channel runs through the prep, snap, multiply and filter states, with a
// bit-serial divider (1 quotient bit a cycle) between prep and snap for each
// channel whose sample lies strictly inside its calibrated span; the frame is
// then loaded and the block returns to idle to accept the next input transaction.
// The filter multiply runs 1 weight bit a cycle, msb first. The frame drains over 8 output
// transactions, overlapped with the next input transaction; a full frame
// register stalls the load.
// Reset restores the calibration registers and centres the filter state.
// ----------------------------------------------------------------------------
`include "joystick_servo_conditioner_unit_assert.svh"

module joystick_servo_conditioner_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  jsc_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output jsc_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [jsc_pkg::REG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [jsc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i
);

  localparam int CH      = jsc_pkg::CHANNELS;
  localparam int SB      = jsc_pkg::SAMPLE_BITS;
  localparam int FB      = jsc_pkg::FRAC_BITS;
  localparam int WB      = jsc_pkg::WEIGHT_BITS;
  localparam int PB      = jsc_pkg::POS_BITS;
  localparam int AB      = PB + WB + 1;
  localparam int FL      = jsc_pkg::FRAME_LEN;
  localparam int CH_BITS = (CH > 1) ? $clog2(CH) : 1;
  localparam int CNT_BITS = $clog2(SB + 1);
  localparam int WIDX_BITS = $clog2(WB);
  localparam int FCNT_BITS = $clog2(FL + 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SNAP = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FILT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [CH_BITS-1:0]   ch_q, ch_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [FCNT_BITS-1:0] frm_cnt_q, frm_cnt_d;

  jsc_pkg::sample_t     cal_low_q [CH];
  jsc_pkg::sample_t     cal_high_q [CH];
  jsc_pkg::sample_t     dz_q;
  logic [WB-1:0]        w_q;
  logic [PB-1:0]        prev_q [CH];

  jsc_pkg::sample_t     samp_q [CH];
  jsc_pkg::sample_t     rem_q, rem_d;
  jsc_pkg::sample_t     quo_q, quo_d;
  jsc_pkg::sample_t     div_q, div_d;
  jsc_pkg::sample_t     x_q, x_d;
  logic signed [PB:0]   dif_q, dif_d;
  logic signed [AB-1:0] acc_q, acc_d;
  logic [7:0]           frame_q [FL];
  logic [7:0]           frame_ld [FL];

  jsc_pkg::sample_t     raw, lo, hi, span;
  logic [2*SB-1:0]      num;
  logic [SB:0]          trial;
  logic                 ge;
  logic signed [SB:0]   off;
  logic [SB:0]          mag;
  logic [WIDX_BITS-1:0] wbit;
  logic signed [AB-1:0] acc_sh;
  logic signed [PB:0]   filt_next;
  logic                 in_acc, out_acc, load;
  logic                 start_byte;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (frm_cnt_q != '0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign load        = (state_q == ST_DONE) && (frm_cnt_q == '0);

  assign out_data_o.frame_byte = frame_q[0];
  assign out_data_o.frame_end  = (frm_cnt_q == FCNT_BITS'(1));
  assign start_byte            = (frame_q[0] == jsc_pkg::FRAME_START);

  // operand selection for the active channel
  assign raw  = samp_q[ch_q];
  assign lo   = cal_low_q[ch_q];
  assign hi   = cal_high_q[ch_q];
  assign span = raw - lo;
  // span * full scale as a shift and subtract
  assign num  = {span, {SB{1'b0}}} - {{SB{1'b0}}, span};

  // one restoring division step
  assign trial = {rem_q, quo_q[SB-1]};
  assign ge    = (trial >= {1'b0, div_q});

  // deadzone distance from centre
  assign off = $signed({1'b0, quo_q}) - $signed((SB+1)'(jsc_pkg::CENTRE));
  assign mag = off[SB] ? (SB+1)'(-off) : (SB+1)'(off);

  // weight bit for this multiply step, msb first
  assign wbit = WIDX_BITS'(WB - 1) - cnt_q[WIDX_BITS-1:0];

  // filter output: x + (w * (prev - x)) / 256, floored
  assign acc_sh    = acc_q >>> FB;
  assign filt_next = $signed({1'b0, x_q, {FB{1'b0}}}) + $signed(acc_sh[PB:0]);

  // sequencer
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    x_d     = x_q;
    dif_d   = dif_q;
    acc_d   = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ch_d    = '0;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        priority if (raw <= lo) begin
          quo_d   = '0;
          state_d = ST_SNAP;
        end else if (raw >= hi) begin
          quo_d   = SB'(jsc_pkg::FULL_SCALE);
          state_d = ST_SNAP;
        end else begin
          rem_d   = num[2*SB-1:SB];
          quo_d   = num[SB-1:0];
          div_d   = hi - lo;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = ge ? SB'(trial - {1'b0, div_q}) : trial[SB-1:0];
        quo_d = {quo_q[SB-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(SB - 1)) begin
          state_d = ST_SNAP;
        end
      end
      ST_SNAP: begin
        x_d     = (mag < {1'b0, dz_q}) ? SB'(jsc_pkg::CENTRE) : quo_q;
        dif_d   = $signed({1'b0, prev_q[ch_q]}) - $signed({1'b0, x_d, {FB{1'b0}}});
        acc_d   = '0;
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        acc_d = (acc_q <<< 1) + (w_q[wbit] ? {{WB{dif_q[PB]}}, dif_q} : AB'(0));
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(WB - 1)) begin
          state_d = ST_FILT;
        end
      end
      ST_FILT: begin
        if (ch_q == CH_BITS'(CH - 1)) begin
          state_d = ST_DONE;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_PREP;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // frame assembly with xor checksum
  always_comb begin
    logic [7:0]    chk;
    jsc_pkg::sample_t pos;
    chk         = '0;
    frame_ld[0] = jsc_pkg::FRAME_START;
    for (int c = 0; c < CH; c++) begin
      pos             = prev_q[c][PB-1:FB];
      frame_ld[1+2*c] = {4'b0000, pos[SB-1:8]};
      frame_ld[2+2*c] = pos[7:0];
      chk             = chk ^ frame_ld[1+2*c] ^ frame_ld[2+2*c];
    end
    frame_ld[FL-1] = chk;
  end

  // frame byte count
  always_comb begin
    frm_cnt_d = frm_cnt_q;
    priority if (load) begin
      frm_cnt_d = FCNT_BITS'(FL);
    end else if (out_acc) begin
      frm_cnt_d = frm_cnt_q - 1'b1;
    end
  end

  // control state, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ch_q      <= '0;
      cnt_q     <= '0;
      frm_cnt_q <= '0;
      dz_q      <= jsc_pkg::DEADZONE_RESET;
      w_q       <= jsc_pkg::WEIGHT_RESET;
      for (int c = 0; c < CH; c++) begin
        cal_low_q[c]  <= jsc_pkg::LOW_RESET_TBL[3'(c)];
        cal_high_q[c] <= jsc_pkg::HIGH_RESET_TBL[3'(c)];
        prev_q[c]     <= PB'(jsc_pkg::CENTRE) << FB;
      end
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      cnt_q     <= cnt_d;
      frm_cnt_q <= frm_cnt_d;
      if (state_q == ST_FILT) begin
        prev_q[ch_q] <= filt_next[PB-1:0];
      end
      if (cfg_we_i) begin
        priority if (cfg_idx_i < jsc_pkg::REG_IDX_BITS'(jsc_pkg::REG_DEADZONE)) begin
          if (cfg_idx_i[0]) begin
            cal_high_q[CH_BITS'(cfg_idx_i >> 1)] <= cfg_wdata_i[SB-1:0];
          end else begin
            cal_low_q[CH_BITS'(cfg_idx_i >> 1)] <= cfg_wdata_i[SB-1:0];
          end
        end else if (cfg_idx_i == jsc_pkg::REG_IDX_BITS'(jsc_pkg::REG_DEADZONE)) begin
          dz_q <= cfg_wdata_i[SB-1:0];
        end else if (cfg_idx_i == jsc_pkg::REG_IDX_BITS'(jsc_pkg::REG_WEIGHT)) begin
          w_q <= cfg_wdata_i[WB-1:0];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    x_q   <= x_d;
    dif_q <= dif_d;
    acc_q <= acc_d;
    if (in_acc) begin
      samp_q[0] <= in_data_i.sample_base;
      samp_q[1] <= in_data_i.sample_shoulder;
      samp_q[2] <= in_data_i.sample_elbow;
    end
    // frame shift register, byte 0 on the output
    if (load) begin
      frame_q <= frame_ld;
    end else if (out_acc) begin
      for (int k = 0; k < FL - 1; k++) begin
        frame_q[k] <= frame_q[k+1];
      end
    end
  end

  // checks
  `JSC_ASSERT(a_rem_below_div, state_q == ST_DIV |-> rem_q < div_q, "remainder not below divisor")
  `JSC_ASSERT(a_filt_nonneg, state_q == ST_FILT |-> !filt_next[PB], "filter result negative")
  `JSC_ASSERT(a_frame_load, load |=> out_valid_o && in_ready_o, "frame not loaded")
  `JSC_ASSERT(a_frame_start, $rose(out_valid_o) |-> start_byte, "frame missing start byte")

endmodule

FILE: tb/joystick_servo_conditioner_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_servo_conditioner_unit_test
// Self-checking bench for the joystick servo conditioner. Input transactions
// go through a bit-accurate remap, deadzone and low-pass predictor that
// builds the expected eight-byte frames, and every output transaction is
// compared byte by byte. Directed corners run first, then random phases under
// varied calibration with bursty input and a receiver that stalls.
// ----------------------------------------------------------------------------
module joystick_servo_conditioner_unit_test;

  // calibration register indexes
  localparam int REG_BASE_LOW      = 0;
  localparam int REG_BASE_HIGH     = 1;
  localparam int REG_SHOULDER_LOW  = 2;
  localparam int REG_SHOULDER_HIGH = 3;
  localparam int REG_ELBOW_LOW     = 4;
  localparam int REG_ELBOW_HIGH    = 5;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 40000;
  localparam int SETTLE_CYCLES = 80;

  localparam int SBITS = jsc_pkg::SAMPLE_BITS;
  localparam int DBITS = jsc_pkg::CFG_DATA_BITS;

  typedef enum int {RX_STREAM, RX_CHOPPY, RX_SPARSE} rx_mode_e;

  // expected frame bytes and the conditioner state behind them
  class frame_scoreboard;
    jsc_pkg::sample_t                 cal_low  [jsc_pkg::CHANNELS];
    jsc_pkg::sample_t                 cal_high [jsc_pkg::CHANNELS];
    jsc_pkg::sample_t                 deadzone;
    logic [jsc_pkg::WEIGHT_BITS-1:0]  weight;
    logic [jsc_pkg::POS_BITS-1:0]     smoothed [jsc_pkg::CHANNELS];
    jsc_pkg::out_t                    frame_q [$];
    int                               failures;

    function new();
      int unsigned centre_pos;
      centre_pos = jsc_pkg::CENTRE << jsc_pkg::FRAC_BITS;
      for (int c = 0; c < jsc_pkg::CHANNELS; c++) begin
        cal_low[c]  = jsc_pkg::LOW_RESET_TBL[c];
        cal_high[c] = jsc_pkg::HIGH_RESET_TBL[c];
        smoothed[c] = centre_pos[jsc_pkg::POS_BITS-1:0];
      end
      deadzone = jsc_pkg::DEADZONE_RESET;
      weight   = jsc_pkg::WEIGHT_RESET;
      failures = 0;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR %0t: %s", $time, msg);
    endfunction

    function void apply_reg(int idx, logic [jsc_pkg::CFG_DATA_BITS-1:0] val);
      if (idx < 2 * jsc_pkg::CHANNELS) begin
        if (idx % 2 == 1) cal_high[idx / 2] = val;
        else cal_low[idx / 2] = val;
      end else if (idx == jsc_pkg::REG_DEADZONE) begin
        deadzone = val;
      end else if (idx == jsc_pkg::REG_WEIGHT) begin
        weight = val[jsc_pkg::WEIGHT_BITS-1:0];
      end
    endfunction

    // accepted input transaction: advance the filters and queue its frame
    function void note_input(jsc_pkg::in_t d);
      jsc_pkg::sample_t  raw [jsc_pkg::CHANNELS];
      int unsigned       lo, hi, x;
      int                off;
      longint unsigned   acc;
      longint unsigned   shifted;
      logic [jsc_pkg::SAMPLE_BITS-1:0] pos;
      logic [7:0]        hi_byte, lo_byte, check;
      raw[0] = d.sample_base;
      raw[1] = d.sample_shoulder;
      raw[2] = d.sample_elbow;
      check = 8'h00;
      frame_q.push_back(jsc_pkg::out_t'{frame_byte: jsc_pkg::FRAME_START, frame_end: 1'b0});
      for (int c = 0; c < jsc_pkg::CHANNELS; c++) begin
        lo = cal_low[c];
        hi = cal_high[c];
        // stretch onto full scale, clamps decide when the span is empty
        if (raw[c] <= lo) x = 0;
        else if (raw[c] >= hi) x = jsc_pkg::FULL_SCALE;
        else x = (raw[c] - lo) * jsc_pkg::FULL_SCALE / (hi - lo);
        // snap to centre strictly inside the deadzone
        off = int'(x) - jsc_pkg::CENTRE;
        if (off > -int'(deadzone) && off < int'(deadzone)) x = jsc_pkg::CENTRE;
        // first-order low-pass with 8 fraction bits
        acc = longint'(weight) * smoothed[c]
            + longint'(256 - int'(weight)) * (longint'(x) << jsc_pkg::FRAC_BITS);
        shifted = acc >> jsc_pkg::FRAC_BITS;
        smoothed[c] = shifted[jsc_pkg::POS_BITS-1:0];
        pos = smoothed[c][jsc_pkg::POS_BITS-1:jsc_pkg::FRAC_BITS];
        hi_byte = {4'h0, pos[11:8]};
        lo_byte = pos[7:0];
        check = check ^ hi_byte ^ lo_byte;
        frame_q.push_back(jsc_pkg::out_t'{frame_byte: hi_byte, frame_end: 1'b0});
        frame_q.push_back(jsc_pkg::out_t'{frame_byte: lo_byte, frame_end: 1'b0});
      end
      frame_q.push_back(jsc_pkg::out_t'{frame_byte: check, frame_end: 1'b1});
    endfunction

    // accepted output transaction against the oldest expected byte
    function void check_result(jsc_pkg::out_t got);
      jsc_pkg::out_t want;
      if (frame_q.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h end %0b", got.frame_byte,
                               got.frame_end));
        return;
      end
      want = frame_q.pop_front();
      if (got.frame_byte !== want.frame_byte)
        note_failure($sformatf("frame_byte expected %02h got %02h", want.frame_byte,
                               got.frame_byte));
      if (got.frame_end !== want.frame_end)
        note_failure($sformatf("frame_end expected %0b got %0b", want.frame_end,
                               got.frame_end));
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  jsc_pkg::in_t                        in_data_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  jsc_pkg::out_t                       out_data_o;
  logic                                cfg_we_i;
  logic [jsc_pkg::REG_IDX_BITS-1:0]    cfg_idx_i;
  logic [jsc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i;

  frame_scoreboard sb = new();
  jsc_pkg::in_t    stimulus_q [$];
  bit              hold_req = 1'b0;

  joystick_servo_conditioner_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic jsc_pkg::in_t triple(int b, int s, int e);
    return jsc_pkg::in_t'{sample_base: b[SBITS-1:0], sample_shoulder: s[SBITS-1:0],
                          sample_elbow: e[SBITS-1:0]};
  endfunction

  // raw sample biased toward the channel's span edges and its middle
  function automatic jsc_pkg::sample_t pick_sample(int c);
    int lo, hi, v;
    lo = sb.cal_low[c];
    hi = sb.cal_high[c];
    case ($urandom_range(0, 5))
      0: v = lo + int'($urandom_range(0, 6)) - 3;
      1: v = hi + int'($urandom_range(0, 6)) - 3;
      2: v = (lo + hi) / 2 + int'($urandom_range(0, 60)) - 30;
      default: v = int'($urandom_range(0, jsc_pkg::FULL_SCALE));
    endcase
    if (v < 0) v = 0;
    if (v > jsc_pkg::FULL_SCALE) v = jsc_pkg::FULL_SCALE;
    return v[SBITS-1:0];
  endfunction

  // one input transaction; valid stays high on return
  task automatic send_item(input jsc_pkg::in_t d);
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(d);
  endtask

  // drain the stimulus queue in bursts with random gaps
  task automatic send_queued();
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 20);
    while (stimulus_q.size() > 0) begin
      send_item(stimulus_q.pop_front());
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 20);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // wait for every expected byte, then let the block settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    while (sb.frame_q.size() > 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (sb.frame_q.size() > 0)
      sb.note_failure($sformatf("%0d bytes never arrived", sb.frame_q.size()));
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all registers while idle
  task automatic load_settings(input int bl, input int bh, input int sl, input int sh,
                               input int el, input int eh, input int dz, input int w);
    logic [jsc_pkg::CFG_DATA_BITS-1:0] vals [jsc_pkg::NUM_REGS];
    vals[REG_BASE_LOW]          = bl[DBITS-1:0];
    vals[REG_BASE_HIGH]         = bh[DBITS-1:0];
    vals[REG_SHOULDER_LOW]      = sl[DBITS-1:0];
    vals[REG_SHOULDER_HIGH]     = sh[DBITS-1:0];
    vals[REG_ELBOW_LOW]         = el[DBITS-1:0];
    vals[REG_ELBOW_HIGH]        = eh[DBITS-1:0];
    vals[jsc_pkg::REG_DEADZONE] = dz[DBITS-1:0];
    vals[jsc_pkg::REG_WEIGHT]   = w[DBITS-1:0];
    for (int i = 0; i < jsc_pkg::NUM_REGS; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[jsc_pkg::REG_IDX_BITS-1:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.apply_reg(i, vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // random calibration, mostly a sane span with some arbitrary ones
  task automatic random_settings();
    int lo [jsc_pkg::CHANNELS];
    int hi [jsc_pkg::CHANNELS];
    int dz;
    for (int c = 0; c < jsc_pkg::CHANNELS; c++) begin
      if ($urandom_range(0, 4) == 0) begin
        lo[c] = $urandom_range(0, jsc_pkg::FULL_SCALE);
        hi[c] = $urandom_range(0, jsc_pkg::FULL_SCALE);
      end else begin
        lo[c] = $urandom_range(0, 1500);
        hi[c] = $urandom_range(2500, jsc_pkg::FULL_SCALE);
      end
    end
    dz = ($urandom_range(0, 5) == 0) ? $urandom_range(0, jsc_pkg::FULL_SCALE)
                                     : $urandom_range(0, 200);
    load_settings(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], dz,
                  $urandom_range(0, jsc_pkg::FULL_SCALE));
  endtask

  // output side: check transactions, stall in runs, honor a long hold-off
  initial begin : receiver
    int       hold_left;
    int       run_left;
    rx_mode_e mode;
    hold_left = 0;
    run_left  = 0;
    mode      = RX_STREAM;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = rx_mode_e'($urandom_range(0, 2));
          run_left = $urandom_range(4, 80);
        end
        run_left--;
        case (mode)
          RX_STREAM: out_ready_i <= 1'b1;
          RX_CHOPPY: out_ready_i <= ($urandom_range(0, 2) != 0);
          default:   out_ready_i <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // reset, directed corners, then random phases
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: clamps, span edges, centre snap, bit patterns
    stimulus_q.push_back(triple(0, 0, 0));
    stimulus_q.push_back(triple(4095, 4095, 4095));
    stimulus_q.push_back(triple(100, 100, 200));
    stimulus_q.push_back(triple(101, 101, 201));
    stimulus_q.push_back(triple(3999, 3999, 3799));
    stimulus_q.push_back(triple(4000, 4000, 3800));
    stimulus_q.push_back(triple(2050, 2050, 2000));
    stimulus_q.push_back(triple(12'hAAA, 12'h555, 12'hAAA));
    stimulus_q.push_back(triple(12'h555, 12'hAAA, 12'h555));
    send_queued();
    wait_idle();

    // full span, no deadzone, no smoothing
    load_settings(0, 4095, 0, 4095, 0, 4095, 0, 12'h000);
    stimulus_q.push_back(triple(2048, 2047, 2049));
    stimulus_q.push_back(triple(0, 4095, 1));
    stimulus_q.push_back(triple(4094, 1, 2048));
    stimulus_q.push_back(triple(12'hFFF, 0, 12'h800));
    send_queued();
    wait_idle();

    // empty or inverted spans, deadzone of half scale, weight bits above the width
    load_settings(2000, 2000, 3000, 1000, 4095, 0, 2048, 12'h1FF);
    stimulus_q.push_back(triple(1999, 3000, 4095));
    stimulus_q.push_back(triple(2000, 3001, 0));
    stimulus_q.push_back(triple(2001, 999, 4094));
    stimulus_q.push_back(triple(0, 4095, 2048));
    send_queued();
    wait_idle();

    // one-count spans, deadzone of one, weight masks to half
    load_settings(1000, 1001, 0, 1, 4094, 4095, 1, 12'h180);
    stimulus_q.push_back(triple(1000, 0, 4094));
    stimulus_q.push_back(triple(1001, 1, 4095));
    stimulus_q.push_back(triple(2048, 2048, 2048));
    send_queued();
    wait_idle();

    // random phases, one of them under a long receiver hold-off
    for (int p = 0; p < 6; p++) begin
      if (p == 0) load_settings(0, 4095, 0, 4095, 0, 4095, 12'hFFF, 12'hEFF);
      else random_settings();
      if (p == 2) hold_req = 1'b1;
      repeat (55) stimulus_q.push_back(jsc_pkg::in_t'{sample_base: pick_sample(0),
                                                      sample_shoulder: pick_sample(1),
                                                      sample_elbow: pick_sample(2)});
      send_queued();
      wait_idle();
    end

    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
